// File: rtl/lidar_range_map_plotter_assert.svh
// assertion macros for the range map plotter rtl
`ifndef LIDAR_RANGE_MAP_PLOTTER_ASSERT_SVH
`define LIDAR_RANGE_MAP_PLOTTER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LRMP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define LRMP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lrmp_pkg.sv
// shared types, codes and trig table for the range map plotter
`timescale 1ns / 1ps

package lrmp_pkg;

	// input modes
	localparam logic [1:0] MODE_BYTE    = 2'd0;
	localparam logic [1:0] MODE_QUERY   = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_CENTER_X    = 2'd0;
	localparam logic [1:0] CFG_CENTER_Y    = 2'd1;
	localparam logic [1:0] CFG_SCALE_SHIFT = 2'd2;

	// configuration reset values
	localparam logic [8:0] CENTER_X_RST    = 9'd159;
	localparam logic [7:0] CENTER_Y_RST    = 8'd119;
	localparam logic [1:0] SCALE_SHIFT_RST = 2'd1;

	// node framing: byte 4 is the last of a node
	localparam logic [2:0] NODE_LAST = 3'd4;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// angle constants in degrees
	localparam logic [9:0] DEG_TURN    = 10'd360;
	localparam logic [9:0] DEG_QUARTER = 10'd90;
	localparam logic [8:0] DEG_90      = 9'd90;
	localparam logic [8:0] DEG_180     = 9'd180;
	localparam logic [8:0] DEG_270     = 9'd270;
	localparam logic [8:0] DEG_360     = 9'd360;

	// pi in q30
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef struct packed {
		logic        is_query;
		logic [8:0]  angle;
		logic [15:0] raw;
	} cmd_t;

	typedef struct packed {
		logic [8:0] center_x;
		logic [7:0] center_y;
		logic [1:0] scale_shift;
	} cfg_t;

	typedef struct packed {
		logic [14:0] mag;
		logic        neg;
	} trig_t;

	// one taylor step: product in q30; the caller divides by the term's factor
	function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] x2);
		return (term * x2) >> 30;
	endfunction

	// q14 sine of k degrees for k in 0..90, elaboration only
	function automatic logic [14:0] sin_quarter_calc(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x    = (64'(k) * PI_Q30) / 64'd180;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = taylor_mul(term, x2) / 64'd6;
		sum  = sum - $signed(term);
		term = taylor_mul(term, x2) / 64'd20;
		sum  = sum + $signed(term);
		term = taylor_mul(term, x2) / 64'd42;
		sum  = sum - $signed(term);
		term = taylor_mul(term, x2) / 64'd72;
		sum  = sum + $signed(term);
		term = taylor_mul(term, x2) / 64'd110;
		sum  = sum - $signed(term);
		term = taylor_mul(term, x2) / 64'd156;
		sum  = sum + $signed(term);
		term = taylor_mul(term, x2) / 64'd210;
		sum  = sum - $signed(term);
		term = taylor_mul(term, x2) / 64'd272;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			sum = '0;
		end
		return 15'(($unsigned(sum) + 64'd32768) >> 16);
	endfunction

	// quarter-wave table, 128 slots, slots past 90 unused
	function automatic logic [128*15-1:0] build_sin_tab();
		logic [128*15-1:0] tab;
		tab = '0;
		for (int k = 0; k <= 90; k++) begin
			tab[k*15 +: 15] = sin_quarter_calc(k);
		end
		return tab;
	endfunction

	localparam logic [128*15-1:0] SIN_TAB = build_sin_tab();

	function automatic logic [14:0] sin_lookup(input logic [6:0] k);
		return SIN_TAB[k*15 +: 15];
	endfunction

	// fold an angle below two turns into one turn
	function automatic logic [8:0] wrap_turn(input logic [9:0] a);
		return (a >= DEG_TURN) ? 9'(a - DEG_TURN) : a[8:0];
	endfunction

	// sine of an angle in 0..359 by quadrant symmetry
	function automatic trig_t sin_deg(input logic [8:0] a);
		logic [8:0] k;
		logic       neg;
		if (a <= DEG_90) begin
			k   = a;
			neg = 1'b0;
		end else if (a <= DEG_180) begin
			k   = DEG_180 - a;
			neg = 1'b0;
		end else if (a <= DEG_270) begin
			k   = a - DEG_180;
			neg = 1'b1;
		end else begin
			k   = DEG_360 - a;
			neg = 1'b1;
		end
		return '{mag: sin_lookup(k[6:0]), neg: neg};
	endfunction

	// floor(v / 5) for v below 8192, by reciprocal multiply
	function automatic logic [10:0] div5(input logic [12:0] v);
		logic [25:0] p;
		p = 26'(v) * 26'd6554;
		return p[25:15];
	endfunction

endpackage

// File: rtl/lrmp_in_if.sv
// input channel: scanner bytes, queries and framing restarts
`timescale 1ns / 1ps

interface lrmp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] scan_byte;
	logic [8:0] query_angle;

	modport source (output valid, output mode, output scan_byte, output query_angle,
		input ready);
	modport sink (input valid, input mode, input scan_byte, input query_angle,
		output ready);
endinterface

// File: rtl/lrmp_out_if.sv
// output channel: distance and screen pixel for one angle
`timescale 1ns / 1ps

interface lrmp_out_if;
	logic               valid;
	logic               ready;
	logic [8:0]         plot_angle;
	logic [10:0]        distance_cm;
	logic signed [10:0] pixel_x;
	logic signed [10:0] pixel_y;

	modport source (output valid, output plot_angle, output distance_cm, output pixel_x,
		output pixel_y, input ready);
	modport sink (input valid, input plot_angle, input distance_cm, input pixel_x,
		input pixel_y, output ready);
endinterface

// File: rtl/lrmp_fifo.sv
// short command queue between the front and the back
`timescale 1ns / 1ps

module lrmp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lrmp_pkg::cmd_t push_cmd,
	output logic           push_ready,
	output logic           pop_valid,
	output lrmp_pkg::cmd_t pop_cmd,
	input  logic           pop
);
	import lrmp_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// File: rtl/lrmp_front.sv
// front: node framing of scanner bytes, query filtering, command push
`timescale 1ns / 1ps

module lrmp_front #(
	parameter int ANGLE_BINS = 360
) (
	input  logic           clk,
	input  logic           arst_n,
	lrmp_in_if.sink        scan_in,
	input  logic           clearing,
	input  logic           push_ready,
	output logic           push,
	output lrmp_pkg::cmd_t push_cmd
);
	import lrmp_pkg::*;

	localparam logic [9:0] BINS = 10'(ANGLE_BINS);

	logic [2:0] phase_q;
	logic [7:0] node_q [3];
	logic [2:0] ph;
	logic [8:0] node_angle;
	logic       accept;

	assign scan_in.ready = push_ready && !clearing;
	assign accept        = scan_in.valid && scan_in.ready;

	// a phase past the last byte of a node counts as the start of a node
	assign ph         = (phase_q > NODE_LAST) ? '0 : phase_q;
	assign node_angle = {node_q[1], node_q[0][7]};

	// classify the beat into a map write, a query or nothing
	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		case (scan_in.mode)
			MODE_BYTE: begin
				push_cmd.is_query = 1'b0;
				push_cmd.angle    = node_angle;
				push_cmd.raw      = {scan_in.scan_byte, node_q[2]};
				push = accept && (ph == NODE_LAST) && ({1'b0, node_angle} < BINS);
			end
			MODE_QUERY: begin
				push_cmd.is_query = 1'b1;
				push_cmd.angle    = scan_in.query_angle;
				push = accept && ({1'b0, scan_in.query_angle} < BINS);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// node framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			node_q[0] <= '0;
			node_q[1] <= '0;
			node_q[2] <= '0;
		end else if (accept) begin
			case (scan_in.mode)
				MODE_BYTE: begin
					case (ph) inside
						[3'd1:3'd3]: node_q[2'(ph - 3'd1)] <= scan_in.scan_byte;
						default: ;
					endcase
					phase_q <= (ph == NODE_LAST) ? '0 : ph + 3'd1;
				end
				MODE_RESTART: begin
					phase_q <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule

// File: rtl/lrmp_back.sv
// back: range map memory, clearing pass and polar to screen pipeline
`timescale 1ns / 1ps
`include "lidar_range_map_plotter_assert.svh"

module lrmp_back #(
	parameter int ANGLE_BINS = 360
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lrmp_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  lrmp_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           clearing,
	lrmp_out_if.source     plot_out
);
	import lrmp_pkg::*;

	localparam int ADDR_W = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(ANGLE_BINS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [15:0]       map_mem [ANGLE_BINS];
	logic [ADDR_W-1:0] cmd_addr;
	logic              adv;

	// stage 1: map read and trig lookup
	logic        v_s1;
	logic [8:0]  angle_s1;
	logic [15:0] raw_s1;
	trig_t       cos_s1;
	trig_t       sin_s1;
	// stage 2: products
	logic        v_s2;
	logic [8:0]  angle_s2;
	logic [30:0] mx_s2;
	logic [30:0] my_s2;
	logic        nx_s2;
	logic        ny_s2;
	logic [12:0] dist8_s2;
	// stage 3: scaled offsets
	logic        v_s3;
	logic [8:0]  angle_s3;
	logic [10:0] qx_s3;
	logic [10:0] qy_s3;
	logic        nx_s3;
	logic        ny_s3;
	logic [10:0] dist_s3;
	// stage 4: result register
	logic               v_s4;
	logic [8:0]         angle_s4;
	logic [10:0]        dist_s4;
	logic signed [10:0] px_s4;
	logic signed [10:0] py_s4;

	logic [4:0]         shift;
	logic [30:0]        sx_shifted;
	logic [30:0]        sy_shifted;
	logic signed [12:0] sum_x;
	logic signed [12:0] sum_y;

	function automatic logic signed [10:0] sat11(input logic signed [12:0] v);
		if (v < -13'sd1024) begin
			return -11'sd1024;
		end else if (v > 13'sd1023) begin
			return 11'sd1023;
		end
		return v[10:0];
	endfunction

	assign clearing = (state_q == ST_CLEAR);
	assign adv      = !v_s4 || plot_out.ready;
	assign q_pop    = q_valid && adv && (state_q == ST_RUN);
	assign cmd_addr = ADDR_W'(q_cmd.angle);

	// clearing pass after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_LAST) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN:  state_q <= ST_RUN;
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// range map: at most one write and one read a cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			map_mem[clr_addr_q] <= '0;
		end else if (q_pop && !q_cmd.is_query) begin
			map_mem[cmd_addr] <= q_cmd.raw;
		end
		if (q_pop) begin
			raw_s1 <= map_mem[cmd_addr];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_pop && q_cmd.is_query;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// offset shift: divide by 8 * 2^(14 + scale), the 5 comes later
	assign shift      = 5'd17 + 5'(cfg.scale_shift);
	assign sx_shifted = mx_s2 >> shift;
	assign sy_shifted = my_s2 >> shift;

	// center plus signed offset
	assign sum_x = $signed({4'b0, cfg.center_x})
		+ (nx_s3 ? -$signed({2'b0, qx_s3}) : $signed({2'b0, qx_s3}));
	assign sum_y = $signed({5'b0, cfg.center_y})
		+ (ny_s3 ? -$signed({2'b0, qy_s3}) : $signed({2'b0, qy_s3}));

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s1 <= q_cmd.angle;
			sin_s1   <= sin_deg(wrap_turn({1'b0, q_cmd.angle}));
			cos_s1   <= sin_deg(wrap_turn({1'b0, q_cmd.angle} + DEG_QUARTER));

			angle_s2 <= angle_s1;
			mx_s2    <= 31'(raw_s1) * 31'(cos_s1.mag);
			my_s2    <= 31'(raw_s1) * 31'(sin_s1.mag);
			nx_s2    <= cos_s1.neg;
			ny_s2    <= sin_s1.neg;
			dist8_s2 <= raw_s1[15:3];

			angle_s3 <= angle_s2;
			qx_s3    <= div5(sx_shifted[12:0]);
			qy_s3    <= div5(sy_shifted[12:0]);
			nx_s3    <= nx_s2;
			ny_s3    <= ny_s2;
			dist_s3  <= div5(dist8_s2);

			angle_s4 <= angle_s3;
			dist_s4  <= dist_s3;
			px_s4    <= sat11(sum_x);
			py_s4    <= sat11(sum_y);
		end
	end

	assign plot_out.valid       = v_s4;
	assign plot_out.plot_angle  = angle_s4;
	assign plot_out.distance_cm = dist_s4;
	assign plot_out.pixel_x     = px_s4;
	assign plot_out.pixel_y     = py_s4;

	`LRMP_ASSERT_IMP(a_no_pop_in_clear, state_q == ST_CLEAR, !q_pop, "command taken during clear")
	`LRMP_ASSERT_NXT(a_query_enters_pipe, q_pop && q_cmd.is_query, v_s1, "query lost at stage 1")
	`LRMP_ASSERT_NXT(a_stall_holds_s3, v_s4 && !plot_out.ready && v_s3, v_s3, "stage 3 dropped in stall")
endmodule

// File: rtl/lidar_range_map_plotter.sv
// top level: configuration registers, front, command queue and back
`timescale 1ns / 1ps

// Scanner range map and plotter. scan_in takes one beat a cycle while ready:
// mode 0 feeds a scanner byte (five bytes to a node; the fifth writes the node's
// raw distance into the map entry of its angle), mode 1 queries an angle, mode 2
// restarts node framing. A query gives one beat on plot_out with distance in whole
// centimetres and the screen pixel from center_x, center_y and scale_shift. The
// range map is a single-port memory of ANGLE_BINS entries that does at most one
// write and one read a cycle, which sets the sustained rate of one item per cycle
// while plot_out is not stalled; a stalled plot_out backs up through a four-entry
// command queue. After reset a clearing pass zeroes the map, and scan_in is not
// ready until it ends. The user must write configuration through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block does not enforce this.
module lidar_range_map_plotter #(
	parameter int ANGLE_BINS = 360
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	lrmp_in_if.sink    scan_in,
	lrmp_out_if.source plot_out
);
	import lrmp_pkg::*;

	cfg_t cfg_q;
	logic push;
	cmd_t push_cmd;
	logic push_ready;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;
	logic clearing;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= CENTER_X_RST;
			cfg_q.center_y    <= CENTER_Y_RST;
			cfg_q.scale_shift <= SCALE_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X:    cfg_q.center_x    <= cfg_data;
				CFG_CENTER_Y:    cfg_q.center_y    <= cfg_data[7:0];
				CFG_SCALE_SHIFT: cfg_q.scale_shift <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	lrmp_front #(
		.ANGLE_BINS (ANGLE_BINS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_in    (scan_in),
		.clearing   (clearing),
		.push_ready (push_ready),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	lrmp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd),
		.pop        (q_pop)
	);

	lrmp_back #(
		.ANGLE_BINS (ANGLE_BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.clearing (clearing),
		.plot_out (plot_out)
	);
endmodule
